### hdl/lbtd_pkg.sv
// shared types and constants for the lru block tag directory
// no dependencies; imported by lbtd_dir and lru_block_tag_directory_top

package lbtd_pkg;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_REMOVE = 1'b1
  } opcode_e;

  // register index of capacity_in_use, taken from paddr[2]
  localparam logic CFG_IDX_CAPACITY = 1'b0;

  localparam logic [4:0] CAPACITY_IN_USE_RESET = 5'd16;

  typedef struct packed {
    logic [31:0] hit_count;
    logic [31:0] request_count;
    logic [31:0] evicted_id;
    logic        evicted;
    logic [3:0]  slot;
    logic        hit;
  } result_t;

endpackage

### hdl/lbtd_dir.sv
// directory core: id store, valid bits, recency ranks, occupancy and counters
// one operation is resolved and committed per step; depends on lbtd_pkg

module lbtd_dir
  import lbtd_pkg::*;
#(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned ID_BITS  = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  opcode_e            opcode_i,
  input  logic [ID_BITS-1:0] key_i,
  input  logic [4:0]         cap_cfg_i,
  output result_t            res_o
);

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned OccW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = (OccW > 5) ? OccW : 5;

  logic [ID_BITS-1:0]  id_q   [CAPACITY];
  logic [CAPACITY-1:0] valid_q, valid_d;
  logic [IdxW-1:0]     rank_q [CAPACITY];
  logic [IdxW-1:0]     rank_d [CAPACITY];
  logic [OccW-1:0]     occ_q, occ_d;
  logic [31:0]         req_q, req_d;
  logic [31:0]         hits_q, hits_d;

  logic [CAPACITY-1:0] match, oldest;
  logic                hit, any_free, is_lookup, evict, install;
  logic [IdxW-1:0]     hit_idx, free_idx, victim_idx, target_idx, slot_idx;
  logic [IdxW-1:0]     hit_rank;
  logic [ID_BITS-1:0]  victim_id;
  logic [OccW-1:0]     occ_m1;
  logic [CmpW-1:0]     limit;
  logic [IdxW+3:0]     slot_ext;
  logic [ID_BITS+31:0] ev_ext;

  assign occ_m1    = occ_q - OccW'(1);
  assign is_lookup = (opcode_i == OP_LOOKUP);

  always_comb begin
    if (cap_cfg_i == 5'd0) begin
      limit = CmpW'(1);
    end else if (CmpW'(cap_cfg_i) > CmpW'(CAPACITY)) begin
      limit = CmpW'(CAPACITY);
    end else begin
      limit = CmpW'(cap_cfg_i);
    end
  end

  // parallel tag compare and recency lookups
  always_comb begin
    hit_idx    = '0;
    free_idx   = '0;
    victim_idx = '0;
    any_free   = 1'b0;
    hit_rank   = '0;
    victim_id  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      match[i]  = valid_q[i] && (id_q[i] == key_i);
      oldest[i] = valid_q[i] && (OccW'(rank_q[i]) == occ_m1);
      if (match[i]) begin
        hit_rank = hit_rank | rank_q[i];
      end
      if (oldest[i]) begin
        victim_id = victim_id | id_q[i];
      end
    end
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = IdxW'(i);
      end
      if (!valid_q[i]) begin
        free_idx = IdxW'(i);
        any_free = 1'b1;
      end
      if (oldest[i]) begin
        victim_idx = IdxW'(i);
      end
    end
  end

  assign hit        = |match;
  assign install    = is_lookup && !hit;
  assign evict      = install && (CmpW'(occ_q) >= limit);
  assign target_idx = any_free ? free_idx : victim_idx;

  always_comb begin
    valid_d = valid_q;
    rank_d  = rank_q;
    occ_d   = occ_q;
    req_d   = req_q;
    hits_d  = hits_q;
    if (step_i) begin
      if (is_lookup) begin
        req_d = req_q + 32'd1;
        if (hit) begin
          hits_d = hits_q + 32'd1;
          for (int i = 0; i < CAPACITY; i++) begin
            if (match[i]) begin
              rank_d[i] = '0;
            end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
              rank_d[i] = rank_q[i] + IdxW'(1);
            end
          end
        end else begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (evict && oldest[i]) begin
              valid_d[i] = 1'b0;
            end else if (valid_q[i]) begin
              rank_d[i] = rank_q[i] + IdxW'(1);
            end
            if (IdxW'(i) == target_idx) begin
              valid_d[i] = 1'b1;
              rank_d[i]  = '0;
            end
          end
          occ_d = evict ? occ_q : occ_q + OccW'(1);
        end
      end else if (hit) begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (match[i]) begin
            valid_d[i] = 1'b0;
            rank_d[i]  = '0;
          end else if (valid_q[i] && (rank_q[i] > hit_rank)) begin
            rank_d[i] = rank_q[i] - IdxW'(1);
          end
        end
        occ_d = occ_q - OccW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
      req_q   <= '0;
      hits_q  <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      occ_q   <= occ_d;
      req_q   <= req_d;
      hits_q  <= hits_d;
      rank_q  <= rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && install) begin
      id_q[target_idx] <= key_i;
    end
  end

  always_comb begin
    if (install) begin
      slot_idx = target_idx;
    end else if (hit) begin
      slot_idx = hit_idx;
    end else begin
      slot_idx = '0;
    end
  end

  assign slot_ext = {4'b0000, slot_idx};
  assign ev_ext   = {32'd0, (evict ? victim_id : {ID_BITS{1'b0}})};

  assign res_o.hit           = hit;
  assign res_o.slot          = slot_ext[3:0];
  assign res_o.evicted       = evict;
  assign res_o.evicted_id    = ev_ext[31:0];
  assign res_o.request_count = req_d;
  assign res_o.hit_count     = hits_d;

  a_occ_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(occ_q))
    else $error("occupancy out of step with valid bits");

  a_evict_not_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_o.evicted) |-> !res_o.hit)
    else $error("eviction reported on a hit");

  a_hit_keeps_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && is_lookup && hit) |=> (occ_q == $past(occ_q)))
    else $error("lookup hit changed occupancy");

  a_miss_installs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && install) |=> (valid_q != '0))
    else $error("lookup miss left the directory empty");

endmodule

### hdl/lru_block_tag_directory_top.sv
// top level of the lru block tag directory: stream channels, input and result
// registers, apb register for capacity_in_use; depends on lbtd_pkg and lbtd_dir

// usage
// s_axis carries one operation per transaction: tuser is the opcode (lookup and
// install, or remove) and tdata the block id. m_axis returns exactly one result
// transaction per operation, in order: hit flag, slot, eviction flag and id,
// and the request and hit counters after the operation.
// an accepted operation waits in the input register, is resolved from it by the tag
// compare and rank update, and is registered in the result register, from which
// it shows on m_axis. the directory state commits in the same cycle the result
// register loads, so one operation per cycle is sustained while m_axis takes
// results.
// when the receiver stalls the result register holds and the input register
// still takes one more operation; s_axis_tready then drops until m_axis drains.
// reset clears all entries, ranks, occupancy and both counters and sets
// capacity_in_use to 16; the block is ready right after reset.
// capacity_in_use sits at byte address 0 of the apb port; write it only while
// no operation is in flight.

module lru_block_tag_directory_top
  import lbtd_pkg::*;
#(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned ID_BITS  = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // operation channel
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // block_id
  input  logic [0:0]   s_axis_tuser,   // opcode
  // result channel
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,   // hit, slot, evicted, evicted_id,
                                       // request_count, hit_count, zero pad
  // register port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic               in_valid_q;
  opcode_e            in_op_q;
  logic [ID_BITS-1:0] in_key_q;
  logic               out_valid_q;
  result_t            out_res_q;
  result_t            res;
  logic [4:0]         cap_q;
  logic               advance;
  logic               cfg_wr;
  logic [ID_BITS+31:0] bid_ext;

  assign bid_ext = {{ID_BITS{1'b0}}, s_axis_tdata};

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op_q  <= opcode_e'(s_axis_tuser[0]);
      in_key_q <= bid_ext[ID_BITS-1:0];
    end
  end

  lbtd_dir #(
    .CAPACITY (CAPACITY),
    .ID_BITS  (ID_BITS)
  ) u_dir (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .opcode_i  (in_op_q),
    .key_i     (in_key_q),
    .cap_cfg_i (cap_q),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_res_q};

  // register port, index taken from paddr[2]
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAPACITY_IN_USE_RESET;
    end else if (cfg_wr && (paddr[2] == CFG_IDX_CAPACITY)) begin
      cap_q <= pwdata[4:0];
    end
  end

  assign prdata = (paddr[2] == CFG_IDX_CAPACITY) ? {27'd0, cap_q} : 32'd0;

endmodule
